[hw/rtl/assert_macros.svh]
// Shared assertion macros for the tag array checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every edge outside reset.
`define CHK_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent on the next edge.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/flsc_pkg.sv]
`default_nettype none
package flsc_pkg;
  localparam int NUM_SETS   = 64;
  localparam int NUM_WAYS   = 4;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 32;

  localparam int SET_BITS = $clog2(NUM_SETS);
  localparam int WAY_BITS = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int TAG_BITS = ADDR_BITS - OFF_BITS;
  localparam int STAMP_BITS = 32;
  localparam int FAULT_BITS = 8;

  // one memory word = one whole set: per way {valid, dirty, tag, stamp}
  localparam int LINE_W = 2 + TAG_BITS + STAMP_BITS;
  localparam int SET_W  = LINE_W * NUM_WAYS;
  localparam int FSET_W = FAULT_BITS * NUM_WAYS;

  typedef struct packed {
    logic                  valid;
    logic                  dirty;
    logic [TAG_BITS-1:0]   tag;
    logic [STAMP_BITS-1:0] stamp;
  } line_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic                hit;
    logic                false_hit;
    logic                miss;
    logic                evicted_valid;
    logic                no_fill;
    logic [1:0]          way_used;
    logic                line_dirty;
  } result_t;
endpackage
`default_nettype wire

[hw/rtl/flsc_ram.sv]
`default_nettype none
module flsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hw/rtl/flsc_update.sv]
`default_nettype none
// Hit detect, victim choice and new set word from one set read.
module flsc_update (
  input  wire logic [flsc_pkg::SET_W-1:0]    set_rd,
  input  wire logic [flsc_pkg::FSET_W-1:0]   flt_rd,
  input  wire logic [flsc_pkg::TAG_BITS-1:0] tag,
  input  wire logic [2:0]                    sblk,
  input  wire logic [7:0]                    full_mask,
  input  wire logic                          is_write,
  input  wire logic [31:0]                   time_now,
  output logic      [flsc_pkg::SET_W-1:0]    set_wr,
  output flsc_pkg::result_t                  res
);
  flsc_pkg::line_t ln [flsc_pkg::NUM_WAYS];
  flsc_pkg::line_t nl [flsc_pkg::NUM_WAYS];
  logic [7:0] fl [flsc_pkg::NUM_WAYS];
  logic found, hit, victim_ok;
  logic [flsc_pkg::WAY_BITS-1:0] mway, vway;
  logic [31:0] best;

  always_comb begin
    for (int w = 0; w < flsc_pkg::NUM_WAYS; w++) begin
      ln[w] = set_rd[w*flsc_pkg::LINE_W +: flsc_pkg::LINE_W];
      fl[w] = flt_rd[w*8 +: 8];
      nl[w] = ln[w];
    end
    found = 1'b0;
    mway  = '0;
    for (int w = flsc_pkg::NUM_WAYS-1; w >= 0; w--) begin
      if (ln[w].valid && ln[w].tag == tag) begin
        found = 1'b1;
        mway  = flsc_pkg::WAY_BITS'(w);
      end
    end
    hit = found && !fl[mway][sblk];
    res = '0;
    res.hit = hit;
    res.false_hit = found && !hit;
    res.miss = !hit;
    if (hit) begin
      nl[mway].stamp = time_now;
      if (is_write) nl[mway].dirty = 1'b1;
      res.way_used = 2'(mway);
      res.line_dirty = nl[mway].dirty;
    end else if (found) begin
      nl[mway] = '0;
      nl[mway].stamp = time_now;
    end
    // victim from post-invalidation stamps
    victim_ok = 1'b0;
    vway = '0;
    best = '0;
    for (int w = 0; w < flsc_pkg::NUM_WAYS; w++) begin
      if ((fl[w] & full_mask) != full_mask) begin
        if (!victim_ok || nl[w].stamp < best) begin
          victim_ok = 1'b1;
          vway = flsc_pkg::WAY_BITS'(w);
          best = nl[w].stamp;
        end
      end
    end
    if (!hit) begin
      if (!victim_ok) begin
        res.no_fill = 1'b1;
      end else begin
        res.evicted_valid = nl[vway].valid;
        res.way_used = 2'(vway);
        nl[vway].valid = 1'b1;
        nl[vway].dirty = 1'b0;
        nl[vway].tag   = tag;
        nl[vway].stamp = time_now;
      end
    end
    for (int w = 0; w < flsc_pkg::NUM_WAYS; w++) begin
      set_wr[w*flsc_pkg::LINE_W +: flsc_pkg::LINE_W] = nl[w];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/faulty_subblock_lru_cache_tags_core.sv]
`default_nettype none
// Set-associative tag array (64 sets x 4 ways) with timestamp LRU and a
// per-line subblock fault map. One set is held as one word of a line RAM
// and one word of a fault RAM, both with registered read. An access steps
// through accept, RAM read, and compare and write back, and its result
// is then held in the output register; the next transaction is taken once
// the previous one has written back and no stalled result is held. After
// reset a clearing pass writes zero to every one of the NUM_SETS (64) sets,
// during which in_stall stays high. A fault load writes its line by a
// read-modify-write of the fault word and returns an all-zero result.
module faulty_subblock_lru_cache_tags_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_sub_blocks_log2,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_address,
  input  wire logic        in_is_write,
  input  wire logic [31:0] in_time_now,
  input  wire logic [5:0]  in_fault_set,
  input  wire logic [1:0]  in_fault_way,
  input  wire logic [7:0]  in_fault_bits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_hit,
  output logic             out_false_hit,
  output logic             out_miss,
  output logic             out_evicted_valid,
  output logic             out_no_fill,
  output logic [1:0]       out_way_used,
  output logic             out_line_dirty
);
  localparam int SB = flsc_pkg::SET_BITS;

  flsc_pkg::state_t state_r, state_nxt;
  logic [SB-1:0] clr_r, clr_nxt;
  logic [1:0]    sbl_r;

  // held transaction
  logic          mode_r, wr_r, fload_ok_r;
  logic [flsc_pkg::TAG_BITS-1:0] tag_r;
  logic [SB-1:0] set_r;
  logic [2:0]    sblk_r;
  logic [31:0]   now_r;
  logic [flsc_pkg::WAY_BITS-1:0] fway_r;
  logic [7:0]    fbits_r;

  logic [flsc_pkg::SET_W-1:0]  set_rd, set_wr;
  logic [flsc_pkg::FSET_W-1:0] flt_rd, flt_wr;
  logic          we_line, we_flt;
  logic [SB-1:0] waddr, raddr;
  flsc_pkg::result_t res, res_r;
  logic [7:0]    full_mask;
  logic          accept, ovalid_r;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != flsc_pkg::ST_IDLE) || (ovalid_r && out_stall);

  // next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      flsc_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SB'(flsc_pkg::NUM_SETS - 1)) state_nxt = flsc_pkg::ST_IDLE;
      end
      flsc_pkg::ST_IDLE:   if (accept) state_nxt = flsc_pkg::ST_LOOKUP;
      flsc_pkg::ST_LOOKUP: state_nxt = flsc_pkg::ST_WRITE;
      flsc_pkg::ST_WRITE:  state_nxt = flsc_pkg::ST_IDLE;
      default:             state_nxt = flsc_pkg::ST_CLEAR;
    endcase
  end

  // RAM controls
  always_comb begin
    we_line = 1'b0;
    we_flt  = 1'b0;
    waddr   = set_r;
    raddr   = set_r;
    flt_wr  = flt_rd;
    case (state_r)
      flsc_pkg::ST_CLEAR: begin
        we_line = 1'b1;
        we_flt  = 1'b1;
        waddr   = clr_r;
        flt_wr  = '0;
      end
      flsc_pkg::ST_WRITE: begin
        if (mode_r) begin
          we_flt = fload_ok_r;
          flt_wr[fway_r*8 +: 8] = fbits_r;
        end else begin
          we_line = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    case (sbl_r)
      2'd0:    full_mask = 8'h01;
      2'd1:    full_mask = 8'h03;
      2'd2:    full_mask = 8'h0f;
      default: full_mask = 8'hff;
    endcase
  end

  flsc_ram #(.WIDTH(flsc_pkg::SET_W), .DEPTH(flsc_pkg::NUM_SETS)) u_line_ram (
    .clk, .we(we_line), .waddr,
    .wdata(state_r == flsc_pkg::ST_CLEAR ? '0 : set_wr),
    .raddr, .rdata(set_rd)
  );
  flsc_ram #(.WIDTH(flsc_pkg::FSET_W), .DEPTH(flsc_pkg::NUM_SETS)) u_fault_ram (
    .clk, .we(we_flt), .waddr, .wdata(flt_wr), .raddr, .rdata(flt_rd)
  );

  flsc_update u_update (
    .set_rd, .flt_rd, .tag(tag_r), .sblk(sblk_r), .full_mask,
    .is_write(wr_r), .time_now(now_r), .set_wr, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= flsc_pkg::ST_CLEAR;
      clr_r    <= '0;
      sbl_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) sbl_r <= cfg_sub_blocks_log2;
      // drop the result once taken, load a new one on write back
      if (state_r == flsc_pkg::ST_WRITE) begin
        ovalid_r <= 1'b1;
      end else if (!out_stall) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // capture transaction fields; subblock index is the top bits of the offset
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_mode;
      wr_r       <= in_is_write;
      tag_r      <= in_address[31:flsc_pkg::OFF_BITS];
      set_r      <= in_mode ? in_fault_set[SB-1:0]
                            : in_address[flsc_pkg::OFF_BITS +: SB];
      sblk_r     <= 3'((in_address[flsc_pkg::OFF_BITS-1 -: 3])
                       >> (2'd3 - sbl_r)) & 3'((4'd1 << sbl_r) - 4'd1);
      now_r      <= in_time_now;
      fway_r     <= in_fault_way[flsc_pkg::WAY_BITS-1:0];
      fbits_r    <= in_fault_bits;
      fload_ok_r <= 1'b1;
    end
    if (state_r == flsc_pkg::ST_WRITE) begin
      res_r <= mode_r ? '0 : res;
    end
  end

  assign out_valid         = ovalid_r;
  assign out_hit           = res_r.hit;
  assign out_false_hit     = res_r.false_hit;
  assign out_miss          = res_r.miss;
  assign out_evicted_valid = res_r.evicted_valid;
  assign out_no_fill       = res_r.no_fill;
  assign out_way_used      = res_r.way_used;
  assign out_line_dirty    = res_r.line_dirty;
endmodule
`default_nettype wire

[hw/rtl/flsc_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module flsc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_hit,
  input wire logic       out_miss,
  input wire logic       out_false_hit,
  input wire logic       out_no_fill,
  input wire logic       out_line_dirty,
  input wire logic [1:0] out_way_used
);
  `CHK_ALWAYS(a_hit_xor_miss, clk, rst_n, !out_valid || !(out_hit && out_miss), "hit/miss clash")
  `CHK_IMPLY(a_fhit_miss, clk, rst_n, out_valid && out_false_hit, out_miss, "false hit not miss")
  `CHK_IMPLY(a_dirty_hit, clk, rst_n, out_valid && out_line_dirty, out_hit, "dirty without hit")
  `CHK_IMPLY(a_nofill_way, clk, rst_n, out_valid && out_no_fill, out_way_used == 2'd0, "no fill way")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result dropped")
endmodule

bind faulty_subblock_lru_cache_tags_core flsc_checker u_flsc_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_hit,
  .out_miss, .out_false_hit, .out_no_fill, .out_line_dirty, .out_way_used
);
`default_nettype wire

[bench/tb_faulty_subblock_lru_cache_tags_core.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_faulty_subblock_lru_cache_tags_core;

  localparam int MODE_ACCESS = 0;
  localparam int MODE_FAULT_LOAD = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NLINES = flsc_pkg::NUM_SETS * flsc_pkg::NUM_WAYS;

  // one input transaction
  typedef struct {
    bit        mode;
    bit [31:0] address;
    bit        is_write;
    bit [31:0] time_now;
    bit [5:0]  fault_set;
    bit [1:0]  fault_way;
    bit [7:0]  fault_bits;
  } req_t;

  // Shadow of the tag array plus the queue of lookup outcomes still due.
  class tag_scoreboard;
    bit [flsc_pkg::TAG_BITS-1:0] tag_mem[NLINES];
    bit                valid_mem[NLINES];
    bit                dirty_mem[NLINES];
    bit [31:0]         stamp_mem[NLINES];
    bit [7:0]          fault_mem[NLINES];
    bit [1:0]          sub_log2;
    flsc_pkg::result_t due_q[$];
    int                errors;
    int                n_hit, n_fhit, n_nofill, n_evict;

    function void note_request(req_t r);
      flsc_pkg::result_t res;
      bit [flsc_pkg::TAG_BITS-1:0] tag;
      int sblk, base, victim, idx;
      bit [7:0] full;
      bit [31:0] oldest;
      res = '0;
      if (r.mode == MODE_FAULT_LOAD) begin
        fault_mem[r.fault_set*flsc_pkg::NUM_WAYS + r.fault_way] = r.fault_bits;
        due_q.push_back(res);
        return;
      end
      tag = r.address[31:flsc_pkg::OFF_BITS];
      sblk = int'((r.address >> (flsc_pkg::OFF_BITS - sub_log2)) & ((1 << sub_log2) - 1));
      full = 8'((1 << (1 << sub_log2)) - 1);
      base = int'(tag[flsc_pkg::SET_BITS-1:0]) * flsc_pkg::NUM_WAYS;
      for (int w = 0; w < flsc_pkg::NUM_WAYS; w++) begin
        idx = base + w;
        if (valid_mem[idx] && tag_mem[idx] == tag) begin
          stamp_mem[idx] = r.time_now;
          if (!fault_mem[idx][sblk]) begin
            res.hit = 1;
            if (r.is_write) dirty_mem[idx] = 1;
            res.way_used = 2'(w);
            res.line_dirty = dirty_mem[idx];
          end else begin
            res.false_hit = 1;
            tag_mem[idx] = '0;
            valid_mem[idx] = 0;
            dirty_mem[idx] = 0;
          end
          break;
        end
      end
      res.miss = !res.hit;
      if (!res.hit) begin
        victim = -1;
        oldest = 0;
        for (int w = 0; w < flsc_pkg::NUM_WAYS; w++) begin
          idx = base + w;
          if ((fault_mem[idx] & full) == full) continue;
          if (victim < 0 || stamp_mem[idx] < oldest) begin
            victim = w;
            oldest = stamp_mem[idx];
          end
        end
        if (victim < 0) res.no_fill = 1;
        else begin
          idx = base + victim;
          res.evicted_valid = valid_mem[idx];
          stamp_mem[idx] = r.time_now;
          tag_mem[idx] = tag;
          valid_mem[idx] = 1;
          dirty_mem[idx] = 0;
          res.way_used = 2'(victim);
        end
      end
      n_hit += res.hit;
      n_fhit += res.false_hit;
      n_nofill += res.no_fill;
      n_evict += res.evicted_valid;
      due_q.push_back(res);
    endfunction

    function void check_result(flsc_pkg::result_t got);
      flsc_pkg::result_t exp_r;
      if (due_q.size() == 0) begin
        $error("result with no outstanding transaction");
        errors++;
        return;
      end
      exp_r = due_q.pop_front();
      if (got.hit !== exp_r.hit) begin
        $error("hit: expected %0d actual %0d", exp_r.hit, got.hit); errors++;
      end
      if (got.false_hit !== exp_r.false_hit) begin
        $error("false_hit: expected %0d actual %0d", exp_r.false_hit, got.false_hit);
        errors++;
      end
      if (got.miss !== exp_r.miss) begin
        $error("miss: expected %0d actual %0d", exp_r.miss, got.miss); errors++;
      end
      if (got.evicted_valid !== exp_r.evicted_valid) begin
        $error("evicted_valid: expected %0d actual %0d", exp_r.evicted_valid,
               got.evicted_valid);
        errors++;
      end
      if (got.no_fill !== exp_r.no_fill) begin
        $error("no_fill: expected %0d actual %0d", exp_r.no_fill, got.no_fill); errors++;
      end
      if (got.way_used !== exp_r.way_used) begin
        $error("way_used: expected %0d actual %0d", exp_r.way_used, got.way_used);
        errors++;
      end
      if (got.line_dirty !== exp_r.line_dirty) begin
        $error("line_dirty: expected %0d actual %0d", exp_r.line_dirty, got.line_dirty);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_sub_blocks_log2 = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_mode = 0;
  logic [31:0] in_address = '0;
  logic        in_is_write = 0;
  logic [31:0] in_time_now = '0;
  logic [5:0]  in_fault_set = '0;
  logic [1:0]  in_fault_way = '0;
  logic [7:0]  in_fault_bits = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        out_hit, out_false_hit, out_miss, out_evicted_valid, out_no_fill;
  logic [1:0]  out_way_used;
  logic        out_line_dirty;

  faulty_subblock_lru_cache_tags_core uut (.*);

  always #5 clk = ~clk;

  tag_scoreboard tags = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  hold_off = 0;      // long receiver stall requested by the stimulus
  int  cycle_count = 0;
  int  items_sent = 0;
  bit [31:0] clock_now = 0;   // monotonic LRU time base
  bit [25:0] tag_pool[8];     // small tag pool so sets see reuse and conflicts

  // Abort on runaway; covers the clearing pass and worst stalls many times.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Sample and check results on the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tags.check_result('{out_hit, out_false_hit, out_miss, out_evicted_valid,
                          out_no_fill, out_way_used, out_line_dirty});
  end

  // Receiver: random stall, or a forced hold-off.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Offer one transaction at a falling edge, hold it until accepted.
  // Valid stays high after acceptance until the next falling edge, where
  // the next send or drain takes it over.
  task automatic send(req_t r);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_mode <= r.mode;
    in_address <= r.address;
    in_is_write <= r.is_write;
    in_time_now <= r.time_now;
    in_fault_set <= r.fault_set;
    in_fault_way <= r.fault_way;
    in_fault_bits <= r.fault_bits;
    do @(posedge clk); while (in_stall);
    tags.note_request(r);
    items_sent++;
  endtask

  task automatic access(bit [31:0] addr, bit wr);
    req_t r;
    r = '{default: 0};
    r.mode = MODE_ACCESS;
    r.address = addr;
    r.is_write = wr;
    clock_now += $urandom_range(3);
    r.time_now = clock_now;
    r.fault_bits = 8'($urandom);
    r.fault_set = 6'($urandom);
    send(r);
  endtask

  task automatic load_faults(bit [5:0] set_i, bit [1:0] way_i, bit [7:0] bits);
    req_t r;
    r = '{default: 0};
    r.mode = MODE_FAULT_LOAD;
    r.fault_set = set_i;
    r.fault_way = way_i;
    r.fault_bits = bits;
    r.address = $urandom;
    r.is_write = 1'($urandom);
    r.time_now = $urandom;
    send(r);
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (tags.due_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_sub_blocks(bit [1:0] v);
    cfg_we <= 1;
    cfg_sub_blocks_log2 <= v;
    @(negedge clk);
    cfg_we <= 0;
    tags.sub_log2 = v;
  endtask

  // Mostly accesses from a small tag pool into few sets, plus fault loads.
  task automatic random_access_mix(int count);
    bit [25:0] t;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 8) begin
        load_faults(6'($urandom_range(3)), 2'($urandom),
                    ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom));
      end else if ($urandom_range(99) < 6) begin
        access($urandom, 1'($urandom));
      end else begin
        t = tag_pool[$urandom_range(7)];
        t[flsc_pkg::SET_BITS-1:0] = 6'($urandom_range(3));
        access({t, 6'($urandom)}, 1'($urandom));
      end
    end
  endtask

  initial begin
    bit [1:0] phase_cfg[3] = '{2'd3, 2'd1, 2'd2};
    foreach (tag_pool[i]) tag_pool[i] = 26'($urandom);
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: extremes, hits, write-dirty, false hit, wholly faulty set.
    set_sub_blocks(2'd0);
    access(32'h0000_0000, 0);
    access(32'h0000_0000, 1);
    access(32'hFFFF_FFFF, 1);
    access(32'hFFFF_FFC0, 0);
    for (int w = 0; w < 5; w++)
      access({26'(w) << flsc_pkg::SET_BITS | 26'd5, 6'h3F}, w[0]);
    load_faults(6'd5, 2'd1, 8'h01);
    access({26'd1 << flsc_pkg::SET_BITS | 26'd5, 6'h00}, 0);   // false hit
    for (int w = 0; w < 4; w++) load_faults(6'd63, 2'(w), 8'hFF);
    access({26'h3FF_FFFF, 6'h00}, 1);                // no fill
    load_faults(6'd63, 2'd2, 8'h00);
    access({26'h3FF_FFFF, 6'h10}, 1);
    access({26'h3FF_FFFF, 6'h10}, 1);
    drain();
    set_sub_blocks(2'd3);
    load_faults(6'd5, 2'd3, 8'h80);
    access({26'd3 << flsc_pkg::SET_BITS | 26'd5, 6'h38}, 0);
    access({26'd3 << flsc_pkg::SET_BITS | 26'd5, 6'h00}, 0);
    drain();

    // Random phases with different idle patterns and subblock counts.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 24 : (p == 1) ? 87 : 0;
      recv_idle_pct = (p == 0) ? 87 : (p == 1) ? 24 : 0;
      set_sub_blocks(phase_cfg[p]);
      if (p == 2) begin
        // hold the receiver off while items keep coming so input stalls
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk);
            hold_off = 0;
          end
          begin
            random_access_mix(40);
            @(negedge clk);
            in_valid <= 0;
          end
        join
      end
      random_access_mix(600);
      drain();
    end

    $display("Covered %0d transactions: %0d hits, %0d false hits, %0d no-fills,",
             items_sent, tags.n_hit, tags.n_fhit, tags.n_nofill);
    $display("%0d valid evictions across all four subblock settings.", tags.n_evict);
    if (tags.errors == 0 && tags.due_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
